@@ hw/rtl/lwbc_pkg.sv @@
package lwbc_pkg;

  localparam int SLOTS          = 8;
  localparam int SLOT_W         = $clog2(SLOTS);
  localparam int CNT_W          = SLOT_W + 1;
  localparam int MAX_FAT_COPIES = 4;
  localparam int COPY_W         = 3;
  localparam int BLK_W          = 32;
  localparam int CFG_W          = 32;
  localparam int CFG_IDX_W      = 2;

  typedef enum logic [1:0] {
    CMD_OPEN = 2'd0,
    CMD_MARK = 2'd1,
    CMD_SYNC = 2'd2,
    CMD_DROP = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_DONE  = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_SLOTS = 2'd0,
    CFG_FAT_FIRST    = 2'd1,
    CFG_FAT_BLOCKS   = 2'd2,
    CFG_FAT_COPIES   = 2'd3
  } cfg_idx_t;

  // datapath operation, each one but OP_NONE emits a result item
  typedef enum logic [3:0] {
    OP_NONE      = 4'd0,
    OP_READ      = 4'd1,
    OP_WRITE     = 4'd2,
    OP_MIRROR    = 4'd3,
    OP_HIT_DONE  = 4'd4,
    OP_MISS_DONE = 4'd5,
    OP_MARK_DONE = 4'd6,
    OP_DROP_DONE = 4'd7,
    OP_SYNC_DONE = 4'd8
  } op_t;

  typedef struct packed {
    op_t  op;
    logic load;
    logic ptr_inc;
    logic track;
    logic pick;
  } ctrl_cmd_t;

  typedef struct packed {
    logic hit;
    logic last;
    logic need_wb;
    logic free_found;
    logic mirror_first;
    logic mirror_more;
  } dp_status_t;

  function automatic logic [CNT_W-1:0] slot_count(input logic [3:0] a);
    logic [CNT_W-1:0] n;
    if (a == 4'd0) begin
      n = CNT_W'(1);
    end else if (32'(a) > SLOTS) begin
      n = CNT_W'(SLOTS);
    end else begin
      n = CNT_W'(a);
    end
    return n;
  endfunction

  function automatic logic [COPY_W-1:0] copy_count(input logic [COPY_W-1:0] a);
    logic [COPY_W-1:0] n;
    if (a == '0) begin
      n = COPY_W'(1);
    end else if (32'(a) > MAX_FAT_COPIES) begin
      n = COPY_W'(MAX_FAT_COPIES);
    end else begin
      n = a;
    end
    return n;
  endfunction

endpackage

@@ hw/rtl/lwbc_ctrl.sv @@
module lwbc_ctrl
  import lwbc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] cmd,
  input  dp_status_t st,
  output ctrl_cmd_t  c,
  output logic       busy
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SCAN   = 8'b0000_0010,
    S_VICTIM = 8'b0000_0100,
    S_EVICT  = 8'b0000_1000,
    S_MIRROR = 8'b0001_0000,
    S_FILL   = 8'b0010_0000,
    S_DONE   = 8'b0100_0000,
    S_SYNC   = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   sync_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sync_mode <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && start) begin
        sync_mode <= (cmd_t'(cmd) == CMD_SYNC);
      end
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_t post_wb;
    logic   post_inc;
    state_next = state;
    c          = '0;
    c.op       = OP_NONE;
    // where to go once a slot has been written back
    post_inc   = 1'b0;
    if (sync_mode) begin
      if (st.last) begin
        post_wb = S_DONE;
      end else begin
        post_wb  = S_SYNC;
        post_inc = 1'b1;
      end
    end else begin
      post_wb = S_FILL;
    end
    case (state)
      S_IDLE: begin
        if (start) begin
          case (cmd_t'(cmd))
            CMD_OPEN: begin
              c.load     = 1'b1;
              state_next = S_SCAN;
            end
            CMD_SYNC: begin
              c.load     = 1'b1;
              state_next = S_SYNC;
            end
            CMD_MARK: c.op = OP_MARK_DONE;
            CMD_DROP: c.op = OP_DROP_DONE;
            default: c.op = OP_NONE;
          endcase
        end
      end
      S_SCAN: begin
        if (st.hit) begin
          c.op       = OP_HIT_DONE;
          state_next = S_IDLE;
        end else begin
          c.track = 1'b1;
          if (st.last) begin
            state_next = S_VICTIM;
          end else begin
            c.ptr_inc = 1'b1;
          end
        end
      end
      S_VICTIM: begin
        c.pick     = 1'b1;
        state_next = S_EVICT;
      end
      S_EVICT: begin
        if (!st.free_found && st.need_wb) begin
          c.op       = OP_WRITE;
          state_next = st.mirror_first ? S_MIRROR : S_FILL;
        end else begin
          c.op       = OP_READ;
          state_next = S_DONE;
        end
      end
      S_MIRROR: begin
        c.op = OP_MIRROR;
        if (!st.mirror_more) begin
          state_next = post_wb;
          c.ptr_inc  = post_inc;
        end
      end
      S_FILL: begin
        c.op       = OP_READ;
        state_next = S_DONE;
      end
      S_SYNC: begin
        if (st.need_wb) begin
          c.op = OP_WRITE;
          if (st.mirror_first) begin
            state_next = S_MIRROR;
          end else begin
            state_next = post_wb;
            c.ptr_inc  = post_inc;
          end
        end else if (st.last) begin
          state_next = S_DONE;
        end else begin
          c.ptr_inc = 1'b1;
        end
      end
      S_DONE: begin
        c.op       = sync_mode ? OP_SYNC_DONE : OP_MISS_DONE;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/lwbc_dpath.sv @@
module lwbc_dpath
  import lwbc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic [BLK_W-1:0]     block_addr,
  input  logic [SLOT_W-1:0]    slot_sel,
  input  ctrl_cmd_t            c,
  output dp_status_t           st,
  output logic                 strobe,
  output logic [1:0]           kind,
  output logic [BLK_W-1:0]     dev_block,
  output logic [SLOT_W-1:0]    slot_out,
  output logic                 was_hit,
  output logic                 last
);

  logic [3:0]        active_slots;
  logic [BLK_W-1:0]  fat_first_block;
  logic [BLK_W-1:0]  fat_blocks;
  logic [COPY_W-1:0] fat_copies;

  logic [BLK_W-1:0]  tag   [SLOTS];
  logic [31:0]       stamp [SLOTS];
  logic [SLOTS-1:0]  present;
  logic [SLOTS-1:0]  dirty;
  logic [31:0]       next_stamp;

  logic [BLK_W-1:0]  blk_q;
  logic [SLOT_W-1:0] ptr;
  logic              free_found;
  logic [SLOT_W-1:0] free_slot;
  logic [SLOT_W-1:0] victim;
  logic [31:0]       best_age;
  logic [BLK_W-1:0]  maddr;
  logic [COPY_W-1:0] mleft;

  logic [CNT_W-1:0]  cnt;
  logic [COPY_W-1:0] copies;
  logic [BLK_W-1:0]  tag_p;
  logic [31:0]       age;
  logic [BLK_W:0]    region_end;
  logic              in_region;
  logic              sel_ok;

  assign cnt        = slot_count(active_slots);
  assign copies     = copy_count(fat_copies);
  assign tag_p      = tag[ptr];
  // wrapped age of the slot under the scan pointer
  assign age        = next_stamp - stamp[ptr];
  assign region_end = {1'b0, fat_first_block} + {1'b0, fat_blocks};
  assign in_region  = (tag_p >= fat_first_block) && ({1'b0, tag_p} < region_end);
  assign sel_ok     = ({1'b0, slot_sel} < cnt);

  assign st.hit          = present[ptr] && (tag_p == blk_q);
  assign st.last         = ({1'b0, ptr} == (cnt - CNT_W'(1)));
  assign st.need_wb      = present[ptr] && dirty[ptr];
  assign st.free_found   = free_found;
  assign st.mirror_first = in_region && (copies > COPY_W'(1));
  assign st.mirror_more  = (mleft > COPY_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      active_slots    <= 4'd8;
      fat_first_block <= '0;
      fat_blocks      <= '0;
      fat_copies      <= COPY_W'(2);
      present         <= '0;
      dirty           <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        tag[i]   <= '0;
        stamp[i] <= '0;
      end
      next_stamp <= '0;
      ptr        <= '0;
      free_found <= 1'b0;
      free_slot  <= '0;
      victim     <= '0;
      best_age   <= '0;
      maddr      <= '0;
      mleft      <= '0;
      blk_q      <= '0;
      strobe     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_ACTIVE_SLOTS: active_slots    <= cfg_wdata[3:0];
          CFG_FAT_FIRST:    fat_first_block <= cfg_wdata[BLK_W-1:0];
          CFG_FAT_BLOCKS:   fat_blocks      <= cfg_wdata[BLK_W-1:0];
          CFG_FAT_COPIES:   fat_copies      <= cfg_wdata[COPY_W-1:0];
          default: ;
        endcase
      end

      strobe <= (c.op != OP_NONE);

      if (c.load) begin
        blk_q      <= block_addr;
        ptr        <= '0;
        free_found <= 1'b0;
      end
      if (c.ptr_inc) begin
        ptr <= ptr + SLOT_W'(1);
      end
      if (c.track) begin
        // last free slot wins; first slot of greatest age wins
        if (!present[ptr]) begin
          free_found <= 1'b1;
          free_slot  <= ptr;
        end
        if (ptr == '0 || age > best_age) begin
          best_age <= age;
          victim   <= ptr;
        end
      end
      if (c.pick) begin
        ptr <= free_found ? free_slot : victim;
      end

      case (c.op)
        OP_WRITE: begin
          dirty[ptr] <= 1'b0;
          maddr      <= tag_p + fat_blocks;
          mleft      <= copies - COPY_W'(1);
        end
        OP_MIRROR: begin
          maddr <= maddr + fat_blocks;
          mleft <= mleft - COPY_W'(1);
        end
        OP_HIT_DONE: begin
          stamp[ptr] <= next_stamp;
          next_stamp <= next_stamp + 32'd1;
        end
        OP_MISS_DONE: begin
          present[ptr] <= 1'b1;
          dirty[ptr]   <= 1'b0;
          tag[ptr]     <= blk_q;
          stamp[ptr]   <= next_stamp;
          next_stamp   <= next_stamp + 32'd1;
        end
        OP_MARK_DONE: begin
          if (sel_ok) begin
            dirty[slot_sel] <= 1'b1;
          end
        end
        OP_DROP_DONE: begin
          if (sel_ok) begin
            present[slot_sel] <= 1'b0;
            dirty[slot_sel]   <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    case (c.op)
      OP_READ: begin
        kind      <= KIND_READ;
        dev_block <= blk_q;
        slot_out  <= ptr;
        was_hit   <= 1'b0;
        last      <= 1'b0;
      end
      OP_WRITE: begin
        kind      <= KIND_WRITE;
        dev_block <= tag_p;
        slot_out  <= ptr;
        was_hit   <= 1'b0;
        last      <= 1'b0;
      end
      OP_MIRROR: begin
        kind      <= KIND_WRITE;
        dev_block <= maddr;
        slot_out  <= ptr;
        was_hit   <= 1'b0;
        last      <= 1'b0;
      end
      OP_HIT_DONE, OP_MISS_DONE: begin
        kind      <= KIND_DONE;
        dev_block <= blk_q;
        slot_out  <= ptr;
        was_hit   <= (c.op == OP_HIT_DONE);
        last      <= 1'b1;
      end
      OP_MARK_DONE, OP_DROP_DONE: begin
        kind      <= KIND_DONE;
        dev_block <= '0;
        slot_out  <= slot_sel;
        was_hit   <= 1'b0;
        last      <= 1'b1;
      end
      OP_SYNC_DONE: begin
        kind      <= KIND_DONE;
        dev_block <= '0;
        slot_out  <= '0;
        was_hit   <= 1'b0;
        last      <= 1'b1;
      end
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/lru_write_back_block_cache.sv @@
// channel | signals                              | handshake
// --------+--------------------------------------+----------------------------
// command | cmd, block_addr, slot_sel            | taken when start && !busy
// result  | kind, dev_block, slot_out, was_hit,  | strobe, one cycle, no stall
//         | last                                 |
// config  | cfg_addr, cfg_wdata                  | written when cfg_we
//
// Mark-dirty and drop keep busy low, so one may be issued every cycle.
// Open scans one slot per cycle and stops at a hit.
// A miss scans all active slots, picks a victim, issues the write-back and mirror
// writes of a dirty victim when no slot is free, then read and done.
// Sync visits each active slot in turn, with a write-back and any mirror writes for a dirty one, then done.
// Results come at most one per cycle, each registered in the cycle after its step; reset empties every slot.
module lru_write_back_block_cache
  import lwbc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           cmd,
  input  logic [BLK_W-1:0]     block_addr,
  input  logic [SLOT_W-1:0]    slot_sel,
  output logic                 strobe,
  output logic [1:0]           kind,
  output logic [BLK_W-1:0]     dev_block,
  output logic [SLOT_W-1:0]    slot_out,
  output logic                 was_hit,
  output logic                 last,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  ctrl_cmd_t  c;
  dp_status_t st;

  lwbc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .st    (st),
    .c     (c),
    .busy  (busy)
  );

  lwbc_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .block_addr (block_addr),
    .slot_sel   (slot_sel),
    .c          (c),
    .st         (st),
    .strobe     (strobe),
    .kind       (kind),
    .dev_block  (dev_block),
    .slot_out   (slot_out),
    .was_hit    (was_hit),
    .last       (last)
  );

  a_last_is_done: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> kind == KIND_DONE)
    else $error("final item is not a done");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    strobe && kind == KIND_DONE |-> last)
    else $error("done item without last");

  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy)
    else $error("device request while idle");

  a_end_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> strobe && last)
    else $error("command ended without done item");

  a_hit_done: assert property (@(posedge clk) disable iff (rst)
    strobe && was_hit |-> kind == KIND_DONE)
    else $error("hit flag on a device request");

endmodule

@@ tb/lwbc_checker.sv @@
`timescale 1ns / 100ps

module lwbc_checker
  import lwbc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  logic [1:0]           cmd,
  input  logic [BLK_W-1:0]     block_addr,
  input  logic [SLOT_W-1:0]    slot_sel,
  input  logic                 strobe,
  input  logic [1:0]           kind,
  input  logic [BLK_W-1:0]     dev_block,
  input  logic [SLOT_W-1:0]    slot_out,
  input  logic                 was_hit,
  input  logic                 last,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   errors,
  output int                   pending
);

  typedef struct packed {
    kind_t             kind;
    logic [BLK_W-1:0]  blk;
    logic [SLOT_W-1:0] slot;
    logic              hit;
    logic              fin;
  } cache_resp_t;

  cache_resp_t resp_q[$];

  // shadow copy of the tag store
  logic [BLK_W-1:0] tag_m   [SLOTS];
  logic             valid_m [SLOTS];
  logic             dirty_m [SLOTS];
  logic [31:0]      stamp_m [SLOTS];
  logic [31:0]      clock_m;

  logic [3:0]       slots_cfg;
  logic [31:0]      fat_first_cfg;
  logic [31:0]      fat_len_cfg;
  logic [2:0]       copies_cfg;

  function automatic void push(kind_t k, logic [BLK_W-1:0] b, int s, logic h, logic f);
    cache_resp_t r;
    r.kind = k;
    r.blk  = b;
    r.slot = s[SLOT_W-1:0];
    r.hit  = h;
    r.fin  = f;
    resp_q.push_back(r);
  endfunction

  function automatic int used_slots();
    int n;
    n = int'(slots_cfg);
    if (n < 1) n = 1;
    if (n > SLOTS) n = SLOTS;
    return n;
  endfunction

  function automatic void write_back(int s);
    int copies;
    logic [32:0] region_end;
    logic [31:0] b;
    if (!valid_m[s] || !dirty_m[s]) return;
    push(KIND_WRITE, tag_m[s], s, 1'b0, 1'b0);
    region_end = {1'b0, fat_first_cfg} + {1'b0, fat_len_cfg};
    if (tag_m[s] >= fat_first_cfg && {1'b0, tag_m[s]} < region_end) begin
      copies = int'(copies_cfg);
      if (copies < 1) copies = 1;
      if (copies > MAX_FAT_COPIES) copies = MAX_FAT_COPIES;
      b = tag_m[s];
      for (int k = 1; k < copies; k++) begin
        b = b + fat_len_cfg;
        push(KIND_WRITE, b, s, 1'b0, 1'b0);
      end
    end
    dirty_m[s] = 1'b0;
  endfunction

  function automatic void run_command(cmd_t c, logic [BLK_W-1:0] blk, logic [SLOT_W-1:0] sel);
    int cnt;
    int free_s;
    int victim;
    logic [31:0] best;
    logic [31:0] age;
    cnt    = used_slots();
    free_s = -1;
    victim = 0;
    best   = '0;
    case (c)
      CMD_OPEN: begin
        for (int i = 0; i < cnt; i++) begin
          if (valid_m[i] && tag_m[i] == blk) begin
            stamp_m[i] = clock_m;
            clock_m    = clock_m + 32'd1;
            push(KIND_DONE, blk, i, 1'b1, 1'b1);
            return;
          end
          if (!valid_m[i]) free_s = i;
          age = clock_m - stamp_m[i];
          if (i == 0 || age > best) begin
            best   = age;
            victim = i;
          end
        end
        // highest free slot wins over the LRU victim
        if (free_s >= 0) victim = free_s;
        else write_back(victim);
        push(KIND_READ, blk, victim, 1'b0, 1'b0);
        valid_m[victim] = 1'b1;
        dirty_m[victim] = 1'b0;
        tag_m[victim]   = blk;
        stamp_m[victim] = clock_m;
        clock_m         = clock_m + 32'd1;
        push(KIND_DONE, blk, victim, 1'b0, 1'b1);
      end
      CMD_MARK: begin
        if (int'(sel) < cnt) dirty_m[sel] = 1'b1;
        push(KIND_DONE, '0, int'(sel), 1'b0, 1'b1);
      end
      CMD_SYNC: begin
        for (int i = 0; i < cnt; i++) write_back(i);
        push(KIND_DONE, '0, 0, 1'b0, 1'b1);
      end
      default: begin
        if (int'(sel) < cnt) begin
          valid_m[sel] = 1'b0;
          dirty_m[sel] = 1'b0;
        end
        push(KIND_DONE, '0, int'(sel), 1'b0, 1'b1);
      end
    endcase
  endfunction

  always @(posedge clk) begin
    cache_resp_t w;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        tag_m[i]   = '0;
        valid_m[i] = 1'b0;
        dirty_m[i] = 1'b0;
        stamp_m[i] = '0;
      end
      clock_m       = '0;
      slots_cfg     = 4'd8;
      fat_first_cfg = '0;
      fat_len_cfg   = '0;
      copies_cfg    = 3'd2;
      resp_q.delete();
    end else begin
      if (strobe) begin
        if (resp_q.size() == 0) begin
          errors = errors + 1;
          if (errors <= 10)
            $display("unexpected result: kind %0d blk %h slot %0d hit %0b last %0b",
                     kind, dev_block, slot_out, was_hit, last);
        end else begin
          w = resp_q.pop_front();
          if (kind !== w.kind || dev_block !== w.blk || slot_out !== w.slot ||
              was_hit !== w.hit || last !== w.fin) begin
            errors = errors + 1;
            if (errors <= 10)
              $display({"mismatch (exp/got): kind %0d/%0d blk %h/%h slot %0d/%0d ",
                        "hit %0b/%0b last %0b/%0b"},
                       w.kind, kind, w.blk, dev_block, w.slot, slot_out,
                       w.hit, was_hit, w.fin, last);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_ACTIVE_SLOTS: slots_cfg     = cfg_wdata[3:0];
          CFG_FAT_FIRST:    fat_first_cfg = cfg_wdata;
          CFG_FAT_BLOCKS:   fat_len_cfg   = cfg_wdata;
          default:          copies_cfg    = cfg_wdata[2:0];
        endcase
      end
      if (start && !busy) run_command(cmd_t'(cmd), block_addr, slot_sel);
    end
    pending = resp_q.size();
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top
  import lwbc_pkg::*;
();

  localparam int CYCLE_LIMIT = 200000;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [1:0]           cmd;
  logic [BLK_W-1:0]     block_addr;
  logic [SLOT_W-1:0]    slot_sel;
  logic                 strobe;
  logic [1:0]           kind;
  logic [BLK_W-1:0]     dev_block;
  logic [SLOT_W-1:0]    slot_out;
  logic                 was_hit;
  logic                 last;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [CFG_W-1:0]     cfg_wdata;
  int                   errors;
  int                   pending;

  int                   n_cycles = 0;
  int                   gap_pct;
  int                   act_now;
  logic [31:0]          fat_first_now;
  logic [31:0]          fat_len_now;
  logic [31:0]          addr_pool [12];

  lru_write_back_block_cache u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .block_addr(block_addr), .slot_sel(slot_sel),
    .strobe(strobe), .kind(kind), .dev_block(dev_block), .slot_out(slot_out),
    .was_hit(was_hit), .last(last),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  lwbc_checker u_chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .block_addr(block_addr), .slot_sel(slot_sel),
    .strobe(strobe), .kind(kind), .dev_block(dev_block), .slot_out(slot_out),
    .was_hit(was_hit), .last(last),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after the item is taken
  task automatic issue(cmd_t c, logic [BLK_W-1:0] b, logic [SLOT_W-1:0] s);
    bit took;
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    start      <= 1'b1;
    cmd        <= c;
    block_addr <= b;
    slot_sel   <= s;
    do begin
      @(posedge clk);
      took = !busy;
      @(negedge clk);
    end while (!took);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // write enable is dropped by the caller after the last write
  task automatic set_reg(cfg_idx_t idx, logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    @(negedge clk);
  endtask

  task automatic configure(int act, logic [31:0] first, logic [31:0] len, int copies);
    drain();
    set_reg(CFG_ACTIVE_SLOTS, CFG_W'(act));
    set_reg(CFG_FAT_FIRST, first);
    set_reg(CFG_FAT_BLOCKS, len);
    set_reg(CFG_FAT_COPIES, CFG_W'(copies));
    cfg_we        <= 1'b0;
    act_now       = act;
    fat_first_now = first;
    fat_len_now   = len;
  endtask

  // pool mixes blocks inside, around the upper end of and outside the table region
  task automatic fill_pool();
    logic [31:0] span;
    span = (fat_len_now == 0) ? 32'd1 : ((fat_len_now > 32'd16) ? 32'd16 : fat_len_now);
    for (int i = 0; i < 12; i++) begin
      case (i % 4)
        0:       addr_pool[i] = fat_first_now + $urandom_range(0, span - 1);
        1:       addr_pool[i] = fat_first_now + fat_len_now - 32'd1 - $urandom_range(0, 1);
        2:       addr_pool[i] = fat_first_now + fat_len_now + $urandom_range(0, 1);
        default: addr_pool[i] = $urandom;
      endcase
    end
  endtask

  task automatic random_items(int n);
    int r;
    int lim;
    logic [SLOT_W-1:0] s;
    lim = (act_now < 1) ? 1 : ((act_now > SLOTS) ? SLOTS : act_now);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if ($urandom_range(99) < 70) s = SLOT_W'($urandom_range(0, lim - 1));
      else s = SLOT_W'($urandom_range(0, SLOTS - 1));
      if (r < 55) begin
        if ($urandom_range(99) < 85) issue(CMD_OPEN, addr_pool[$urandom_range(0, 11)], s);
        else issue(CMD_OPEN, $urandom, s);
      end else if (r < 77) begin
        issue(CMD_MARK, $urandom, s);
      end else if (r < 87) begin
        issue(CMD_SYNC, $urandom, s);
      end else begin
        issue(CMD_DROP, $urandom, s);
      end
      if ($urandom_range(24) == 0) drain();
    end
  endtask

  initial begin
    gap_pct    = 0;
    act_now    = 8;
    rst        = 1'b1;
    start      = 1'b0;
    cmd        = CMD_OPEN;
    block_addr = '0;
    slot_sel   = '0;
    cfg_we     = 1'b0;
    cfg_addr   = CFG_ACTIVE_SLOTS;
    cfg_wdata  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: no table region, slot 0 tag zero but free
    issue(CMD_OPEN, 32'd0, 3'd0);
    issue(CMD_MARK, 32'd0, 3'd7);
    issue(CMD_SYNC, 32'd0, 3'd0);

    configure(8, 32'd100, 32'd10, 3);
    issue(CMD_OPEN, 32'd105, 3'd0);
    issue(CMD_OPEN, 32'hFFFF_FFFF, 3'd0);
    issue(CMD_OPEN, 32'd0, 3'd0);
    issue(CMD_MARK, 32'd0, 3'd6);
    issue(CMD_MARK, 32'd0, 3'd5);
    issue(CMD_DROP, 32'd0, 3'd5);
    issue(CMD_MARK, 32'd0, 3'd4);   // free slot marked dirty, never written
    issue(CMD_SYNC, 32'd0, 3'd0);
    issue(CMD_OPEN, 32'd109, 3'd0);
    issue(CMD_OPEN, 32'd110, 3'd0); // just past the region
    issue(CMD_OPEN, 32'd100, 3'd0);
    issue(CMD_OPEN, 32'd99, 3'd0);
    issue(CMD_OPEN, 32'd1, 3'd0);
    issue(CMD_OPEN, 32'd2, 3'd0);
    issue(CMD_MARK, 32'd0, 3'd6);
    issue(CMD_OPEN, 32'hAAAA_AAAA, 3'd0); // evicts the dirty table block
    issue(CMD_MARK, 32'd0, 3'd3);
    issue(CMD_OPEN, 32'h5555_5555, 3'd0);
    issue(CMD_OPEN, 32'd105, 3'd0);

    configure(8, $urandom, $urandom_range(1, 20), 2);
    fill_pool();
    random_items(27);

    gap_pct = 55;
    configure(15, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 7);
    fill_pool();
    random_items(27);

    gap_pct = 14;
    configure(0, 32'd0, 32'hFFFF_FFFF, 0);
    fill_pool();
    random_items(27);

    gap_pct = 30;
    configure(1, $urandom, 32'd0, 4);
    fill_pool();
    random_items(27);

    gap_pct = 55;
    configure(3, $urandom, $urandom_range(1, 8), 1);
    fill_pool();
    random_items(27);

    gap_pct = 0;
    configure(5, 32'd0, 32'd4, 4);
    fill_pool();
    random_items(27);

    gap_pct = 14;
    configure(8, $urandom, 32'hFFFF_FFFF, 4);
    fill_pool();
    random_items(27);

    drain();
    repeat (20) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
